/* hw/rtl/mfde_pkg.sv */
// Package: shared types and constants of the framebuffer draw engine.
`timescale 1ns / 1ps
package mfde_pkg;
  localparam int unsigned ScreenWidthDefault  = 128;
  localparam int unsigned ScreenHeightDefault = 64;
  localparam int unsigned RowStride  = 128;
  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned AddrW      = 10;

  typedef enum logic [3:0] {
    KIND_PIXEL = 4'd0, KIND_HLINE = 4'd1, KIND_VLINE = 4'd2, KIND_RECT = 4'd3,
    KIND_FILL = 4'd4, KIND_BOX = 4'd5, KIND_GLYPH = 4'd6, KIND_CLEAR = 4'd7,
    KIND_READ = 4'd8
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PLAN, ST_WALK, ST_RD, ST_WR, ST_CLR, ST_RDB, ST_RDW, ST_DONE
  } state_e;

  // One walk: a run of pixels from (x,y) stepping in x or y.
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] len;
    logic       vert;
    logic       ink;
    logic       glyph;
  } seg_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [7:0]  span_width;
    logic [7:0]  span_height;
    logic        ink;
    logic [63:0] glyph_bits;
    logic [9:0]  byte_addr;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       command_done;
  } rsp_t;
endpackage

/* hw/rtl/mfde_if.sv */
// Interfaces: valid/ready channels for command and response items.
`timescale 1ns / 1ps
interface mfde_cmd_if import mfde_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfde_rsp_if import mfde_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/mono_framebuffer_draw_engine.sv */
// Top level: command sequencer over a read-modify-write frame memory.
// Throughput: one command at a time. A drawn pixel passes the step, read and write states,
// a clipped one, or an unset glyph bit, only the step.
// Clear and the clearing pass walk all 1024 bytes, one per cycle.
// A read byte command passes the RDB, RDW and DONE states; a response waits in a register.
// After reset the memory is swept to zero; no item is taken then.
`timescale 1ns / 1ps
module mono_framebuffer_draw_engine import mfde_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDefault,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mfde_cmd_if.sink     cmd_i,
  mfde_rsp_if.source   rsp_o
);
  logic [7:0] mem_q [StoreDepth];
  logic [7:0] rdata_q;

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic [2:0] phase_q, phase_d;
  seg_t   seg_q, seg_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] row_q, row_d;
  logic [AddrW-1:0] sweep_q, sweep_d;
  logic rsp_valid_q, rsp_valid_d;
  logic [7:0] rsp_data_q, rsp_data_d;
  logic seg_ok;

  logic we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0] wdata;

  // Current pixel of the walk.
  logic [7:0] px, py;
  logic [7:0] gcol;
  logic       on_screen, pix_en;
  assign px = seg_q.vert ? seg_q.x : 8'(seg_q.x + cnt_q);
  assign py = seg_q.vert ? 8'(seg_q.y + cnt_q) : seg_q.y;
  assign gcol = cmd_q.glyph_bits[{cnt_q[2:0], 3'b000} +: 8];
  assign on_screen = (px < 8'(SCREEN_WIDTH)) && (py < 8'(SCREEN_HEIGHT));
  assign pix_en = on_screen && (!seg_q.glyph || gcol[row_q[2:0]]);
  logic [AddrW-1:0] paddr;
  assign paddr = AddrW'({2'b00, px} + (AddrW'(py[7:3]) * AddrW'(RowStride)));
  logic [7:0] pmask;
  assign pmask = 8'(1) << py[2:0];

  assign cmd_i.ready = (state_q == ST_IDLE) && !rsp_valid_q;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = '{read_data: rsp_data_q, command_done: 1'b1};

  // Plan next segment of a command from its phase and row; seg_ok=0 means finished.
  always_comb begin
    seg_d = seg_q;
    seg_ok = 1'b1;
    seg_d.glyph = 1'b0;
    seg_d.ink = 1'b1;
    unique case (kind_e'(cmd_q.kind))
      KIND_PIXEL: begin
        seg_d = '{x: cmd_q.x_pos, y: cmd_q.y_pos, len: 8'd1, vert: 1'b0,
                  ink: cmd_q.ink, glyph: 1'b0};
        seg_ok = (phase_q == 3'd0);
      end
      KIND_HLINE: begin
        seg_d = '{x: cmd_q.x_pos, y: cmd_q.y_pos, len: cmd_q.span_width, vert: 1'b0,
                  ink: cmd_q.ink, glyph: 1'b0};
        seg_ok = (phase_q == 3'd0);
      end
      KIND_VLINE: begin
        seg_d = '{x: cmd_q.x_pos, y: cmd_q.y_pos, len: cmd_q.span_height, vert: 1'b1,
                  ink: cmd_q.ink, glyph: 1'b0};
        seg_ok = (phase_q == 3'd0);
      end
      KIND_RECT, KIND_BOX: begin
        case (phase_q)
          3'd0: seg_d = '{x: cmd_q.x_pos, y: cmd_q.y_pos, len: cmd_q.span_width,
                          vert: 1'b0, ink: 1'b1, glyph: 1'b0};
          3'd1: seg_d = '{x: cmd_q.x_pos, y: 8'(cmd_q.y_pos + cmd_q.span_height - 8'd1),
                          len: cmd_q.span_width, vert: 1'b0, ink: 1'b1, glyph: 1'b0};
          3'd2: seg_d = '{x: cmd_q.x_pos, y: cmd_q.y_pos, len: cmd_q.span_height,
                          vert: 1'b1, ink: 1'b1, glyph: 1'b0};
          3'd3: seg_d = '{x: 8'(cmd_q.x_pos + cmd_q.span_width - 8'd1), y: cmd_q.y_pos,
                          len: cmd_q.span_height, vert: 1'b1, ink: 1'b1, glyph: 1'b0};
          3'd4: begin
            seg_d = '{x: 8'(cmd_q.x_pos + 8'd1), y: 8'(cmd_q.y_pos + 8'd1 + row_q),
                      len: 8'(cmd_q.span_width - 8'd2), vert: 1'b0, ink: 1'b0,
                      glyph: 1'b0};
            seg_ok = (kind_e'(cmd_q.kind) == KIND_BOX) &&
                     (row_q < 8'(cmd_q.span_height - 8'd2));
          end
          default: seg_ok = 1'b0;
        endcase
      end
      KIND_FILL: begin
        seg_d = '{x: cmd_q.x_pos, y: 8'(cmd_q.y_pos + row_q), len: cmd_q.span_width,
                  vert: 1'b0, ink: cmd_q.ink, glyph: 1'b0};
        seg_ok = (row_q < cmd_q.span_height);
      end
      KIND_GLYPH: begin
        // Row-major walk: one horizontal run of 8 columns per glyph row.
        seg_d = '{x: cmd_q.x_pos, y: 8'(cmd_q.y_pos + row_q), len: 8'd8, vert: 1'b0,
                  ink: 1'b1, glyph: 1'b1};
        seg_ok = (row_q < 8'd8);
      end
      default: seg_ok = 1'b0;
    endcase
  end

  // Sequencer: plan segments, read-modify-write each drawn pixel, sweep for clear and reset, read bytes.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d = cnt_q;
    row_d = row_q;
    sweep_d = sweep_q;
    rsp_valid_d = rsp_valid_q;
    rsp_data_d = rsp_data_q;
    we = 1'b0;
    re = 1'b0;
    waddr = paddr;
    raddr = paddr;
    wdata = seg_q.ink ? (rdata_q | pmask) : (rdata_q & ~pmask);
    if (rsp_valid_q && rsp_o.ready) rsp_valid_d = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLR: begin
        we = 1'b1;
        waddr = sweep_q;
        wdata = '0;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == AddrW'(StoreDepth - 1)) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (cmd_i.valid && cmd_i.ready) begin
          phase_d = '0;
          row_d = '0;
          sweep_d = '0;
          rsp_data_d = '0;
          unique case (kind_e'(cmd_i.data.kind))
            KIND_CLEAR: state_d = ST_CLR;
            KIND_READ:  state_d = ST_RDB;
            default:    state_d = ST_PLAN;
          endcase
        end
      end
      ST_PLAN: begin
        cnt_d = '0;
        state_d = seg_ok ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        if (cnt_q == seg_q.len) begin
          // Segment over: step the row counter for fill-style kinds, else the phase.
          state_d = ST_PLAN;
          if (seg_q.glyph || kind_e'(cmd_q.kind) == KIND_FILL ||
              (phase_q == 3'd4)) begin
            row_d = row_q + 8'd1;
          end else begin
            phase_d = phase_q + 3'd1;
          end
        end else if (pix_en) begin
          re = 1'b1;
          state_d = ST_RD;
        end else begin
          cnt_d = cnt_q + 8'd1;
        end
      end
      ST_RD: state_d = ST_WR;
      ST_WR: begin
        we = 1'b1;
        cnt_d = cnt_q + 8'd1;
        state_d = ST_WALK;
      end
      ST_RDB: begin
        re = 1'b1;
        raddr = cmd_q.byte_addr;
        state_d = ST_RDW;
      end
      ST_RDW: begin
        rsp_data_d = rdata_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q) begin
          rsp_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Frame memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // Hold the accepted command and walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) cmd_q <= cmd_i.data;
    if (state_q == ST_PLAN) seg_q <= seg_d;
    rsp_data_q <= rsp_data_d;
    cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      phase_q <= '0;
      row_q <= '0;
      sweep_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      row_q <= row_d;
      sweep_q <= sweep_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end
endmodule

/* tb/tb.sv */
// Testbench for the page-organized monochrome framebuffer draw engine.
`timescale 1ns / 1ps
module tb;
  import mfde_pkg::*;

  // Scoreboard: shadow frame buffer plus queue of pending responses
  class frame_scoreboard;
    bit [7:0] shadow_fb [StoreDepth];
    rsp_t     pending_rsp [$];
    int       errors;

    function new();
      foreach (shadow_fb[i]) shadow_fb[i] = '0;
      errors = 0;
    endfunction

    function void plot(bit [7:0] x, bit [7:0] y, bit on);
      int unsigned a;
      if (x >= ScreenWidthDefault || y >= ScreenHeightDefault) return;
      a = (x + RowStride * (y >> 3)) % StoreDepth;
      shadow_fb[a][y[2:0]] = on;
    endfunction

    function void hrun(bit [7:0] x, bit [7:0] y, bit [7:0] len, bit on);
      for (int i = 0; i < len; i++) plot(x + 8'(i), y, on);
    endfunction

    function void vrun(bit [7:0] x, bit [7:0] y, bit [7:0] len, bit on);
      for (int i = 0; i < len; i++) plot(x, y + 8'(i), on);
    endfunction

    function void outline(bit [7:0] x, bit [7:0] y, bit [7:0] w, bit [7:0] h);
      hrun(x, y, w, 1'b1);
      hrun(x, y + h - 8'd1, w, 1'b1);
      vrun(x, y, h, 1'b1);
      vrun(x + w - 8'd1, y, h, 1'b1);
    endfunction

    function void fill(bit [7:0] x, bit [7:0] y, bit [7:0] w, bit [7:0] h, bit on);
      for (int i = 0; i < h; i++) hrun(x, y + 8'(i), w, on);
    endfunction

    // Apply one accepted command to the shadow and queue its response
    function void note_command(cmd_t c);
      rsp_t r;
      r.read_data    = '0;
      r.command_done = 1'b1;
      case (c.kind)
        KIND_PIXEL: plot(c.x_pos, c.y_pos, c.ink);
        KIND_HLINE: hrun(c.x_pos, c.y_pos, c.span_width, c.ink);
        KIND_VLINE: vrun(c.x_pos, c.y_pos, c.span_height, c.ink);
        KIND_RECT:  outline(c.x_pos, c.y_pos, c.span_width, c.span_height);
        KIND_FILL:  fill(c.x_pos, c.y_pos, c.span_width, c.span_height, c.ink);
        KIND_BOX: begin
          outline(c.x_pos, c.y_pos, c.span_width, c.span_height);
          fill(c.x_pos + 8'd1, c.y_pos + 8'd1, c.span_width - 8'd2,
               c.span_height - 8'd2, 1'b0);
        end
        KIND_GLYPH: begin
          for (int col = 0; col < 8; col++)
            for (int row = 0; row < 8; row++)
              if (c.glyph_bits[col*8 + row])
                plot(c.x_pos + 8'(col), c.y_pos + 8'(row), 1'b1);
        end
        KIND_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
        KIND_READ:  r.read_data = shadow_fb[c.byte_addr];
        default: ;
      endcase
      pending_rsp.push_back(r);
    endfunction

    // Compare one accepted response with the oldest pending one
    function void check_response(rsp_t got);
      rsp_t exp_r;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response read_data=%h done=%b",
                 $time, got.read_data, got.command_done);
        errors++;
        return;
      end
      exp_r = pending_rsp.pop_front();
      if (got.read_data !== exp_r.read_data) begin
        $display("%0t: read_data mismatch expected %h actual %h",
                 $time, exp_r.read_data, got.read_data);
        errors++;
      end
      if (got.command_done !== exp_r.command_done) begin
        $display("%0t: command_done mismatch expected %b actual %b",
                 $time, exp_r.command_done, got.command_done);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;      // when set, both sides run without gaps
  bit   stim_done;

  mfde_cmd_if cmd_if ();
  mfde_rsp_if rsp_if ();
  frame_scoreboard sb;

  mono_framebuffer_draw_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .rsp_o  (rsp_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic cmd_t make_cmd(kind_e k, bit [7:0] x, bit [7:0] y, bit [7:0] w,
                                    bit [7:0] h, bit ink, bit [63:0] g, bit [9:0] a);
    cmd_t c;
    c.kind = k; c.x_pos = x; c.y_pos = y; c.span_width = w; c.span_height = h;
    c.ink = ink; c.glyph_bits = g; c.byte_addr = a;
    return c;
  endfunction

  // Drive one command; valid stays high across back-to-back items
  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(c);
  endtask

  // Random command, mostly small spans near the screen
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25)      c.kind = KIND_READ;
    else if (sel < 35) c.kind = KIND_PIXEL;
    else if (sel < 45) c.kind = KIND_HLINE;
    else if (sel < 55) c.kind = KIND_VLINE;
    else if (sel < 65) c.kind = KIND_RECT;
    else if (sel < 74) c.kind = KIND_FILL;
    else if (sel < 82) c.kind = KIND_BOX;
    else if (sel < 94) c.kind = KIND_GLYPH;
    else if (sel < 96) c.kind = KIND_CLEAR;
    else               c.kind = 4'($urandom_range(9, 15));
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      c.x_pos = 8'($urandom_range(0, 135));
      c.y_pos = 8'($urandom_range(0, 70));
    end else if (sel < 8) begin
      c.x_pos = 8'($urandom_range(240, 255));
      c.y_pos = 8'($urandom_range(240, 255));
    end else begin
      c.x_pos = 8'($urandom);
      c.y_pos = 8'($urandom);
    end
    if ($urandom_range(0, 199) == 0) begin
      c.span_width  = 8'($urandom_range(128, 255));
      c.span_height = 8'($urandom_range(64, 255));
    end else if ($urandom_range(0, 9) == 0 && c.kind != KIND_FILL && c.kind != KIND_BOX) begin
      c.span_width  = 8'($urandom);
      c.span_height = 8'($urandom);
    end else begin
      c.span_width  = 8'($urandom_range(0, 20));
      c.span_height = 8'($urandom_range(0, 20));
    end
    c.ink        = 1'($urandom);
    c.glyph_bits = {$urandom, $urandom};
    c.byte_addr  = 10'($urandom);
    return c;
  endfunction

  // Stimulus
  initial begin
    cmd_t dir_q [$];
    sb = new();
    calm = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: extremes, every kind, clipping, wrap and zero spans
    dir_q.push_back(make_cmd(KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_PIXEL, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, 10'd0));
    dir_q.push_back(make_cmd(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, 10'd1023));
    dir_q.push_back(make_cmd(KIND_HLINE, 8'd250, 8'd9, 8'd20, 8'd0, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_HLINE, 8'd5, 8'd5, 8'd0, 8'd0, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_VLINE, 8'd3, 8'd250, 8'd0, 8'd30, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, 10'd3));
    dir_q.push_back(make_cmd(KIND_RECT, 8'd10, 8'd10, 8'd0, 8'd0, 1'b0, '0, '0));
    dir_q.push_back(make_cmd(KIND_RECT, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, '0, '0));
    dir_q.push_back(make_cmd(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, 10'd128));
    dir_q.push_back(make_cmd(KIND_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_BOX, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, 10'd517));
    dir_q.push_back(make_cmd(KIND_BOX, 8'd20, 8'd20, 8'd1, 8'd1, 1'b1, '0, '0));
    dir_q.push_back(make_cmd(KIND_FILL, 8'd30, 8'd8, 8'd40, 8'd16, 1'b0, '0, '0));
    dir_q.push_back(make_cmd(KIND_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, '0));
    dir_q.push_back(make_cmd(KIND_GLYPH, 8'd124, 8'd60, 8'd0, 8'd0, 1'b0, '1, '0));
    dir_q.push_back(make_cmd(KIND_GLYPH, 8'd60, 8'd252, 8'd0, 8'd0, 1'b0,
                             64'hA5C3_0F81_7E18_FF01, '0));
    dir_q.push_back(make_cmd(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, 10'd892));
    dir_q.push_back(make_cmd(kind_e'(4'd9), 8'd1, 8'd1, 8'd1, 8'd1, 1'b1, '1, '1));
    dir_q.push_back(make_cmd(kind_e'(4'd15), 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, '0));
    foreach (dir_q[i]) send_cmd(dir_q[i]);

    // Random: phases that are gapped or, now and then, gap-free
    for (int n = 0; n < 1250; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      send_cmd(rand_cmd());
    end
    @(negedge clk_i) cmd_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Response side: random stalls, checked at the rising edge
  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      @(negedge clk_i);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_response(rsp_if.data);
    end
  end

  // End of run: drain, let the block settle, then report
  initial begin
    wait (stim_done);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* mono_framebuffer_draw_engine.f */
hw/rtl/mfde_pkg.sv
hw/rtl/mfde_if.sv
hw/rtl/mono_framebuffer_draw_engine.sv
tb/tb.sv
